// ===== src/assert_macros.svh =====
// Assertion macros used by the display controller top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== src/sadc_pkg.sv =====
// Package with the item types and constants of the display controller.
`timescale 1ns / 1ps
package sadc_pkg;
    localparam int unsigned WORD_W = 26;
    localparam logic [25:0] BLANK_CH   = 26'h20;
    localparam logic [25:0] CUSTOM_BIT = 26'h2000000;
    localparam logic [25:0] BLANK_BIT  = 26'h1000000;
    localparam logic [25:0] KEEP_MARKS = 26'h1ff0000;
    localparam logic [25:0] DROP_POINT = 26'h300ffff;
    localparam logic [25:0] POINT_MASK = 26'h0ff0000;
    localparam logic [1:0] MODE_PINS = 2'd0;
    localparam logic [1:0] MODE_TICK = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic       reset_pin;
        logic       clock_pin;
        logic       data_pin;
        logic [3:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic [25:0] char_word;
        logic [25:0] flash_word;
        logic        flash_active;
        logic        changed;
        logic        is_enabled;
    } out_item_t;
endpackage

// ===== src/serial_alphanumeric_display_controller.sv =====
// Top level of the 16-character serial display controller.
// Items that touch no store go straight to S_DONE; a read passes through S_RD, a point mark
// through S_PTRD and S_PTWR, a character write through S_PTRD, S_PTWR, S_RD and S_WR, a scroll
// also sweeps its window, and blank, clear, flash capture or internal reset sweep all 16 entries.
// Throughput: one item at a time; a new item is taken only back in S_IDLE, with the output free.
// Reset: rst_n clears all control state; both stores are cleared by a 16-entry pass after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module serial_alphanumeric_display_controller
    import sadc_pkg::*;
#(
    parameter int unsigned PHASE_TICKS = 20
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);
    localparam logic [4:0] PT = 5'(PHASE_TICKS);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_WR    = 4'd3;
    localparam logic [3:0] S_SWEEP = 4'd4;
    localparam logic [3:0] S_SWRD  = 4'd5;
    localparam logic [3:0] S_DONE  = 4'd6;
    localparam logic [3:0] S_PTRD  = 4'd7;
    localparam logic [3:0] S_PTWR  = 4'd8;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_BLANK = 3'd1;
    localparam logic [2:0] OP_CLEAR = 3'd2;
    localparam logic [2:0] OP_SCRL  = 3'd3;
    localparam logic [2:0] OP_SCRR  = 3'd4;
    localparam logic [2:0] OP_FLASH = 3'd5;
    localparam logic [2:0] OP_RESET = 3'd6;

    logic [25:0] cmem [16];
    logic [25:0] fmem [16];
    logic [25:0] crd_reg, frd_reg;
    logic        c_we, f_we;
    logic [3:0]  c_wa, c_ra, f_a;
    logic [25:0] c_wd, f_wd;

    always_ff @(posedge clk)
    begin
        if (c_we)
            cmem[c_wa] <= c_wd;
        crd_reg <= cmem[c_ra];
        if (f_we)
            fmem[f_a] <= f_wd;
        frd_reg <= fmem[f_a];
    end

    logic [3:0] st_reg, st_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [2:0] op_reg, op_next;
    logic [7:0] arg_reg, arg_next;
    logic [25:0] x_reg, x_next;
    logic [3:0] wp_reg, wp_next, sp_reg, sp_next, lw_reg, lw_next, wf_reg, wf_next;
    logic [3:0] wl_reg, wl_next, fr_reg, fr_next, tgt_reg, tgt_next, ridx_reg, ridx_next;
    logic [1:0] em_reg, em_next, cp_reg, cp_next;
    logic [7:0] sb_reg, sb_next, fc_reg, fc_next;
    logic [2:0] bc_reg, bc_next;
    logic cl_reg, cl_next, en_reg, en_next, pp_reg, pp_next, fp_reg, fp_next;
    logic [15:0] cb_reg, cb_next;
    logic [4:0] pt_reg, pt_next;
    logic upd_reg, upd_next, rd_reg, rd_next, ptfix_reg, ptfix_next;
    logic ov_reg, ov_next;
    out_item_t od_reg, od_next;

    assign in_ready  = (st_reg == S_IDLE) && (!ov_reg || out_ready);
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    function automatic logic inwin(input logic [3:0] i, input logic [3:0] f,
                                   input logic [3:0] l);
        inwin = (i >= f) && (i <= l);
    endfunction

    logic [3:0] ci;
    logic [7:0] nb;
    logic [25:0] xv;
    logic blk, go;

    always_comb
    begin
        st_next = st_reg; cnt_next = cnt_reg; op_next = op_reg; arg_next = arg_reg;
        x_next = x_reg; wp_next = wp_reg; sp_next = sp_reg; lw_next = lw_reg;
        wf_next = wf_reg; wl_next = wl_reg; fr_next = fr_reg; tgt_next = tgt_reg;
        ridx_next = ridx_reg; em_next = em_reg; cp_next = cp_reg; sb_next = sb_reg;
        fc_next = fc_reg; bc_next = bc_reg; cl_next = cl_reg; en_next = en_reg;
        pp_next = pp_reg; fp_next = fp_reg; cb_next = cb_reg; pt_next = pt_reg;
        upd_next = upd_reg; rd_next = rd_reg; ptfix_next = ptfix_reg;
        ov_next = ov_reg; od_next = od_reg;
        c_we = 1'b0; c_wa = '0; c_wd = '0; c_ra = '0;
        f_we = 1'b0; f_a = '0; f_wd = '0;
        ci = cnt_reg[3:0]; nb = '0; xv = '0; blk = 1'b0; go = 1'b0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        case (st_reg)
            S_INIT:
            begin
                c_we = 1'b1; c_wa = ci; c_wd = BLANK_CH;
                f_we = 1'b1; f_a = ci; f_wd = '0;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                    st_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    upd_next = 1'b0; rd_next = 1'b0; op_next = OP_NONE;
                    ridx_next = in_data.read_index; cnt_next = '0;
                    st_next = S_DONE;
                    case (in_data.mode)
                        MODE_READ:
                        begin
                            rd_next = 1'b1; st_next = S_RD;
                            c_ra = in_data.read_index; f_a = in_data.read_index;
                        end
                        MODE_TICK:
                        begin
                            if (pt_reg != 5'd0)
                            begin
                                pt_next = pt_reg - 5'd1;
                                if (pt_reg == 5'd1)
                                begin
                                    pt_next = PT;
                                    if (!fp_reg)
                                    begin
                                        if (fr_reg >= 4'd1 && fr_reg <= 4'd3)
                                        begin
                                            op_next = OP_FLASH; st_next = S_SWEEP;
                                            fp_next = 1'b1; upd_next = 1'b1;
                                        end
                                    end
                                    else
                                    begin
                                        fc_next = fc_reg - 8'd1;
                                        if (fc_reg == 8'd1)
                                            pt_next = '0;
                                        if (fr_reg != 4'd0)
                                        begin
                                            fp_next = 1'b0; upd_next = 1'b1;
                                        end
                                    end
                                end
                            end
                        end
                        MODE_PINS:
                        begin
                            if (!in_data.reset_pin)
                                en_next = 1'b0;
                            else
                            begin
                                if (!en_reg)
                                begin
                                    upd_next = 1'b1; op_next = OP_RESET; st_next = S_SWEEP;
                                    wp_next = '0; sp_next = '0; bc_next = '0; sb_next = '0;
                                    wf_next = '0; wl_next = 4'd15; em_next = '0;
                                    fc_next = '0; fr_next = '0; fp_next = 1'b0;
                                    pt_next = '0; en_next = 1'b1;
                                    cl_next = in_data.clock_pin;
                                end
                                else if (in_data.clock_pin != cl_reg)
                                begin
                                    cl_next = in_data.clock_pin;
                                    if (!in_data.clock_pin)
                                    begin
                                        nb = {sb_reg[6:0], ~in_data.data_pin};
                                        sb_next = nb;
                                        bc_next = bc_reg + 3'd1;
                                        if (bc_reg == 3'd7)
                                            go = 1'b1;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                    if (go)
                    begin
                        if (nb[7] && cp_reg == 2'd0)
                        begin
                            pp_next = 1'b0;
                            arg_next = nb;
                            case (nb[7:4])
                                4'h8:
                                    if (nb[3:2] == 2'b00)
                                    begin
                                        op_next = OP_BLANK; st_next = S_SWEEP;
                                        upd_next = 1'b1;
                                    end
                                4'h9:
                                begin
                                    wp_next = nb[3:0]; sp_next = nb[3:0];
                                end
                                4'hA:
                                    if (nb[3:2] == 2'b00)
                                        em_next = nb[1:0];
                                4'hB:
                                    if (nb[3:0] >= 4'd1 && nb[3:0] <= 4'd3)
                                    begin
                                        op_next = OP_CLEAR; st_next = S_SWEEP;
                                        upd_next = 1'b1;
                                    end
                                4'hC:
                                begin
                                    fc_next = {4'd0, nb[3:0]};
                                    if (nb[3:0] == 4'd0 && fp_reg)
                                    begin
                                        fp_next = 1'b0; upd_next = 1'b1;
                                    end
                                    pt_next = PT;
                                end
                                4'hD:
                                begin
                                    fr_next = nb[3:0];
                                    if (nb[3:0] == 4'd0 && fp_reg)
                                    begin
                                        pt_next = '0; fp_next = 1'b0; upd_next = 1'b1;
                                    end
                                end
                                4'hE: wf_next = nb[3:0];
                                default: wl_next = nb[3:0];
                            endcase
                        end
                        else
                        begin
                            xv = {18'd0, nb};
                            blk = 1'b0;
                            if (cp_reg != 2'd0)
                            begin
                                cb_next = {nb, cb_reg[15:8]};
                                cp_next = cp_reg - 2'd1;
                                if (cp_reg != 2'd1)
                                    blk = 1'b1;
                                xv = {10'd0, nb, cb_reg[15:8]} | CUSTOM_BIT;
                            end
                            if (!blk)
                            begin
                                if (xv == 26'd37 || xv == 26'd38 || xv == 26'd59)
                                    blk = 1'b1;
                                else if (xv == 26'd58)
                                begin
                                    cp_next = 2'd2; cb_next = '0; blk = 1'b1;
                                end
                            end
                            if (!blk)
                            begin
                                x_next = xv;
                                ptfix_next = 1'b0;
                                if (xv == 26'd46 || xv == 26'd44)
                                begin
                                    pp_next = 1'b0;
                                    ptfix_next = 1'b1;
                                    c_ra = lw_reg; st_next = S_PTRD;
                                end
                                else
                                begin
                                    ptfix_next = pp_reg;
                                    pp_next = 1'b1;
                                    c_ra = lw_reg;
                                    st_next = S_PTRD;
                                end
                            end
                        end
                    end
                end
            end
            S_PTRD:
            begin
                c_ra = lw_reg;
                st_next = S_PTWR;
            end
            S_PTWR:
            begin
                if (x_reg == 26'd46 || x_reg == 26'd44)
                begin
                    if ((crd_reg & POINT_MASK) == '0)
                        upd_next = 1'b1;
                    c_we = 1'b1; c_wa = lw_reg; c_wd = crd_reg | (x_reg << 16);
                    st_next = S_DONE;
                end
                else
                begin
                    if (ptfix_reg && (crd_reg & POINT_MASK) != '0)
                    begin
                        c_we = 1'b1; c_wa = lw_reg; c_wd = crd_reg & DROP_POINT;
                        upd_next = 1'b1;
                    end
                    lw_next = wp_reg;
                    tgt_next = wp_reg;
                    st_next = S_RD;
                    if (em_reg == 2'd0)
                        wp_next = wp_reg + 4'd1;
                    else if (em_reg == 2'd1)
                        wp_next = wp_reg - 4'd1;
                    else if (em_reg == 2'd2)
                    begin
                        if (sp_reg < wl_reg)
                        begin
                            sp_next = wp_reg; wp_next = wp_reg + 4'd1;
                        end
                        else
                        begin
                            op_next = OP_SCRL; lw_next = wl_reg; tgt_next = wl_reg;
                            upd_next = 1'b1; cnt_next = {1'b0, wf_reg};
                            st_next = S_SWEEP;
                        end
                    end
                    else
                    begin
                        if (sp_reg > wf_reg)
                        begin
                            sp_next = wp_reg; wp_next = wp_reg - 4'd1;
                        end
                        else
                        begin
                            op_next = OP_SCRR; lw_next = wf_reg; tgt_next = wf_reg;
                            upd_next = 1'b1; cnt_next = {1'b0, wl_reg};
                            st_next = S_SWEEP;
                        end
                    end
                end
            end
            S_RD:
            begin
                // Read path for report, or character write target address.
                c_ra = rd_reg ? ridx_reg : tgt_reg;
                f_a = ridx_reg;
                if (rd_reg)
                    st_next = S_DONE;
                else
                begin
                    c_ra = tgt_reg;
                    st_next = S_WR;
                end
            end
            S_WR:
            begin
                c_we = 1'b1; c_wa = tgt_reg;
                c_wd = (crd_reg & KEEP_MARKS) | x_reg;
                if (op_reg != OP_SCRL && op_reg != OP_SCRR &&
                    {10'd0, crd_reg[15:0]} != x_reg)
                    upd_next = 1'b1;
                st_next = S_DONE;
            end
            S_SWEEP:
            begin
                // Issue a read of the entry to transform.
                if (op_reg == OP_SCRL)
                    c_ra = (cnt_reg[3:0] < wl_reg) ? ci + 4'd1 : ci;
                else if (op_reg == OP_SCRR)
                    c_ra = (cnt_reg[3:0] > wf_reg) ? ci - 4'd1 : ci;
                else
                    c_ra = ci;
                st_next = S_SWRD;
            end
            S_SWRD:
            begin
                st_next = S_SWEEP;
                case (op_reg)
                    OP_BLANK:
                    begin
                        c_we = 1'b1; c_wa = ci; c_wd = crd_reg;
                        if (arg_reg[1:0] == 2'd0 ||
                            (arg_reg[1:0] == 2'd1 && !inwin(ci, wf_reg, wl_reg)) ||
                            (arg_reg[1:0] == 2'd2 && ci >= wf_reg && ci < wl_reg))
                            c_wd = crd_reg | BLANK_BIT;
                        if (arg_reg[1:0] == 2'd3)
                            c_wd = crd_reg & ~BLANK_BIT;
                    end
                    OP_CLEAR:
                        if (arg_reg[1:0] == 2'd3 ||
                            (arg_reg[1:0] == 2'd2 && !inwin(ci, wf_reg, wl_reg)) ||
                            (arg_reg[1:0] == 2'd1 && ci >= wf_reg && ci < wl_reg))
                        begin
                            c_we = 1'b1; c_wa = ci; c_wd = BLANK_CH;
                        end
                    OP_RESET:
                    begin
                        c_we = 1'b1; c_wa = ci; c_wd = BLANK_CH;
                    end
                    OP_FLASH:
                    begin
                        f_we = 1'b1; f_a = ci;
                        blk = fr_reg == 4'd3 ||
                              (fr_reg == 4'd1 && inwin(ci, wf_reg, wl_reg)) ||
                              (fr_reg == 4'd2 && !inwin(ci, wf_reg, wl_reg));
                        f_wd = blk ? BLANK_CH : crd_reg;
                    end
                    default:
                    begin
                        c_we = 1'b1; c_wa = ci; c_wd = crd_reg;
                    end
                endcase
                if (op_reg == OP_SCRL)
                begin
                    if (cnt_reg[3:0] >= wl_reg || wf_reg > wl_reg)
                    begin
                        c_we = 1'b0; op_next = OP_NONE; st_next = S_RD;
                    end
                    else
                        cnt_next = cnt_reg + 5'd1;
                end
                else if (op_reg == OP_SCRR)
                begin
                    if (cnt_reg[3:0] <= wf_reg || wf_reg > wl_reg)
                    begin
                        c_we = 1'b0; op_next = OP_NONE; st_next = S_RD;
                    end
                    else
                        cnt_next = cnt_reg - 5'd1;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                    if (cnt_reg == 5'd15)
                        st_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    od_next.char_word    = rd_reg ? crd_reg : '0;
                    od_next.flash_word   = rd_reg ? frd_reg : '0;
                    od_next.flash_active = fp_reg;
                    od_next.changed      = upd_reg;
                    od_next.is_enabled   = en_reg;
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_INIT; cnt_reg <= '0; op_reg <= OP_NONE; arg_reg <= '0;
            wp_reg <= '0; sp_reg <= '0; lw_reg <= '0; wf_reg <= '0; wl_reg <= 4'd15;
            fr_reg <= '0; tgt_reg <= '0; ridx_reg <= '0; em_reg <= '0; cp_reg <= '0;
            sb_reg <= '0; fc_reg <= '0; bc_reg <= '0; cl_reg <= 1'b0; en_reg <= 1'b0;
            pp_reg <= 1'b0; fp_reg <= 1'b0; cb_reg <= '0; pt_reg <= '0;
            upd_reg <= 1'b0; rd_reg <= 1'b0; ptfix_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; cnt_reg <= cnt_next; op_reg <= op_next; arg_reg <= arg_next;
            wp_reg <= wp_next; sp_reg <= sp_next; lw_reg <= lw_next; wf_reg <= wf_next;
            wl_reg <= wl_next; fr_reg <= fr_next; tgt_reg <= tgt_next;
            ridx_reg <= ridx_next; em_reg <= em_next; cp_reg <= cp_next;
            sb_reg <= sb_next; fc_reg <= fc_next; bc_reg <= bc_next; cl_reg <= cl_next;
            en_reg <= en_next; pp_reg <= pp_next; fp_reg <= fp_next; cb_reg <= cb_next;
            pt_reg <= pt_next; upd_reg <= upd_next; rd_reg <= rd_next;
            ptfix_reg <= ptfix_next; ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg  <= x_next;
        od_reg <= od_next;
    end

    `CHK_IMPL(a_ready_idle, clk, rst_n, in_ready, st_reg == S_IDLE, "ready outside idle")
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
    `CHK_IMPL(a_no_write_idle, clk, rst_n, st_reg == S_IDLE, !c_we && !f_we, "write in idle")
endmodule

// ===== test/tb_serial_alphanumeric_display_controller.sv =====
// Self-checking testbench for the serial alphanumeric display controller.
`timescale 1ns / 1ps
module tb_serial_alphanumeric_display_controller;
    import sadc_pkg::*;

    localparam int PHASE = 20;
    localparam int WATCH_LIMIT = 20000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    serial_alphanumeric_display_controller #(.PHASE_TICKS(PHASE)) uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
        .out_data(out_data)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state.
    logic [25:0] shown [16];
    logic [25:0] flashed [16];
    logic [3:0] wr_pos, scr_pos, mark_pos, win_lo, win_hi, fl_region;
    logic [1:0] entry, cust_left;
    logic [7:0] sh_byte, fl_count;
    logic [2:0] nbits;
    logic clk_lvl, enabled, pt_pending, fl_phase;
    logic [15:0] cust_word;
    logic [4:0] ph_timer;

    out_item_t expected_q[$];
    int errors;
    int accepted_in;
    int accepted_out;
    int idle_cycles = 0;

    function automatic bit in_win(int i);
        return i >= win_lo && i <= win_hi;
    endfunction

    function automatic void display_clear();
        clk_lvl = 0; wr_pos = 0; scr_pos = 0; nbits = 0; sh_byte = 0;
        for (int i = 0; i < 16; i++) shown[i] = BLANK_CH;
        win_lo = 0; win_hi = 15; entry = 0; fl_count = 0; fl_region = 0;
        fl_phase = 0; ph_timer = 0; enabled = 0;
    endfunction

    function automatic bit put_code(logic [3:0] pos, logic [25:0] x);
        bit diff;
        diff = {10'd0, shown[pos][15:0]} != x;
        shown[pos] = (shown[pos] & KEEP_MARKS) | x;
        return diff;
    endfunction

    function automatic bit run_command(logic [7:0] x);
        bit upd;
        logic [3:0] lo;
        upd = 0;
        lo = x[3:0];
        case (x[7:4])
            4'h8:
                if (lo < 4)
                begin
                    for (int i = 0; i < 16; i++)
                    begin
                        if (lo == 0 || (lo == 1 && !in_win(i)) ||
                            (lo == 2 && i >= win_lo && i < win_hi))
                            shown[i] |= BLANK_BIT;
                        if (lo == 3) shown[i] &= ~BLANK_BIT;
                    end
                    upd = 1;
                end
            4'h9:
            begin
                wr_pos = lo;
                scr_pos = lo;
            end
            4'ha: if (lo < 4) entry = lo[1:0];
            4'hb:
                if (lo >= 1 && lo <= 3)
                begin
                    for (int i = 0; i < 16; i++)
                        if (lo == 3 || (lo == 2 && !in_win(i)) ||
                            (lo == 1 && i >= win_lo && i < win_hi))
                            shown[i] = BLANK_CH;
                    upd = 1;
                end
            4'hc:
            begin
                fl_count = {4'd0, lo};
                if (lo == 0 && fl_phase)
                begin
                    fl_phase = 0;
                    upd = 1;
                end
                ph_timer = 5'(PHASE);
            end
            4'hd:
            begin
                fl_region = lo;
                if (lo == 0 && fl_phase)
                begin
                    ph_timer = 0;
                    fl_phase = 0;
                    upd = 1;
                end
            end
            4'he: win_lo = lo;
            default: win_hi = lo;
        endcase
        return upd;
    endfunction

    function automatic bit accept_byte(logic [7:0] b);
        bit upd;
        logic [25:0] x;
        upd = 0;
        x = {18'd0, b};
        if (b[7] && cust_left == 0)
        begin
            upd = run_command(b);
            pt_pending = 0;
            return upd;
        end
        if (cust_left != 0)
        begin
            cust_word = {b, cust_word[15:8]};
            cust_left = cust_left - 2'd1;
            if (cust_left != 0) return 0;
            x = {10'd0, cust_word} | CUSTOM_BIT;
        end
        if (x == 37 || x == 38 || x == 59) return 0;
        if (x == 58)
        begin
            cust_left = 2;
            cust_word = 0;
            return 0;
        end
        if (x == 46 || x == 44)
        begin
            if ((shown[mark_pos] & POINT_MASK) == 0) upd = 1;
            shown[mark_pos] |= x << 16;
            pt_pending = 0;
            return upd;
        end
        if (pt_pending && (shown[mark_pos] & POINT_MASK) != 0)
        begin
            shown[mark_pos] &= DROP_POINT;
            upd = 1;
        end
        mark_pos = wr_pos;
        pt_pending = 1;
        case (entry)
            2'd0:
            begin
                upd |= put_code(wr_pos, x);
                wr_pos = wr_pos + 4'd1;
            end
            2'd1:
            begin
                upd |= put_code(wr_pos, x);
                wr_pos = wr_pos - 4'd1;
            end
            2'd2:
                if (scr_pos < win_hi)
                begin
                    scr_pos = wr_pos;
                    upd |= put_code(wr_pos, x);
                    wr_pos = wr_pos + 4'd1;
                end
                else
                begin
                    for (int i = win_lo; i < win_hi; i++) shown[i] = shown[i + 1];
                    void'(put_code(win_hi, x));
                    mark_pos = win_hi;
                    upd = 1;
                end
            default:
                if (scr_pos > win_lo)
                begin
                    scr_pos = wr_pos;
                    upd |= put_code(wr_pos, x);
                    wr_pos = wr_pos - 4'd1;
                end
                else
                begin
                    for (int i = win_hi; i > win_lo; i--) shown[i] = shown[i - 1];
                    void'(put_code(win_lo, x));
                    mark_pos = win_lo;
                    upd = 1;
                end
        endcase
        return upd;
    endfunction

    function automatic bit timer_tick();
        bit blank;
        if (ph_timer == 0) return 0;
        ph_timer = ph_timer - 5'd1;
        if (ph_timer != 0) return 0;
        ph_timer = 5'(PHASE);
        if (!fl_phase)
        begin
            if (fl_region < 1 || fl_region > 3) return 0;
            for (int i = 0; i < 16; i++)
            begin
                blank = fl_region == 3 || (fl_region == 1 && in_win(i)) ||
                        (fl_region == 2 && !in_win(i));
                flashed[i] = blank ? BLANK_CH : shown[i];
            end
            fl_phase = 1;
            return 1;
        end
        fl_count = fl_count - 8'd1;
        if (fl_count == 0) ph_timer = 0;
        if (fl_region != 0)
        begin
            fl_phase = 0;
            return 1;
        end
        return 0;
    endfunction

    function automatic bit sample_pins(logic r, logic c, logic d);
        bit upd;
        upd = 0;
        if (!r)
        begin
            enabled = 0;
            return 0;
        end
        if (!enabled)
        begin
            display_clear();
            enabled = 1;
            upd = 1;
            clk_lvl = c;
        end
        if (c != clk_lvl)
        begin
            if (!c)
            begin
                sh_byte = {sh_byte[6:0], ~d};
                nbits = nbits + 3'd1;
                if (nbits == 0) upd |= accept_byte(sh_byte);
            end
            clk_lvl = c;
        end
        return upd;
    endfunction

    function automatic out_item_t display_predict(in_item_t it);
        out_item_t r;
        bit upd;
        upd = 0;
        r = '0;
        if (it.mode == MODE_PINS) upd = sample_pins(it.reset_pin, it.clock_pin, it.data_pin);
        else if (it.mode == MODE_TICK) upd = timer_tick();
        else if (it.mode == MODE_READ)
        begin
            r.char_word = shown[it.read_index];
            r.flash_word = flashed[it.read_index];
        end
        r.flash_active = fl_phase;
        r.changed = upd;
        r.is_enabled = enabled;
        return r;
    endfunction

    // The valid line stays high between items sent back to back.
    task automatic drive_item(in_item_t it);
        int gap;
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        accepted_in++;
    endtask

    task automatic idle_input();
        in_valid <= 1'b0;
    endtask

    task automatic send_item(in_item_t it);
        expected_q.push_back(display_predict(it));
        drive_item(it);
    endtask

    function automatic in_item_t pin_item(logic r, logic c, logic d);
        in_item_t it;
        it = '0;
        it.mode = MODE_PINS;
        it.reset_pin = r;
        it.clock_pin = c;
        it.data_pin = d;
        it.read_index = 4'($urandom);
        return it;
    endfunction

    // Two pin samples per bit: clock high then low, data inverted on the wire.
    task automatic send_byte(logic [7:0] b);
        for (int i = 7; i >= 0; i--)
        begin
            send_item(pin_item(1'b1, 1'b1, ~b[i]));
            send_item(pin_item(1'b1, 1'b0, ~b[i]));
        end
    endtask

    task automatic send_read(logic [3:0] idx);
        in_item_t it;
        it = '0;
        it.mode = MODE_READ;
        it.read_index = idx;
        send_item(it);
    endtask

    task automatic send_tick();
        in_item_t it;
        it = '0;
        it.mode = MODE_TICK;
        it.read_index = 4'($urandom);
        send_item(it);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'($urandom_range(32, 126));
            3: return 8'($urandom_range(0, 255));
            4: return 8'($urandom_range(128, 255));
            5: return ($urandom_range(0, 1)) ? 8'd46 : 8'd44;
            6: return 8'd58;
            7: return 8'h90 | 8'($urandom_range(0, 15));
            8: return 8'ha0 | 8'($urandom_range(0, 4));
            default: return 8'hc0 | 8'($urandom_range(0, 63));
        endcase
    endfunction

    // Directed table: a row with typed set carries a typed-in result, one without uses the predictor.
    typedef struct {
        in_item_t    item;
        bit          typed;
        out_item_t   result;
    } stim_row_t;

    stim_row_t table_rows[$];

    function automatic stim_row_t row_of(in_item_t it, bit typed, out_item_t r);
        stim_row_t s;
        s.item = it;
        s.typed = typed;
        s.result = r;
        return s;
    endfunction

    // Output side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                accepted_out++;
                if (expected_q.size() == 0)
                begin
                    $error("result with nothing expected");
                    errors++;
                end
                else
                begin
                    automatic out_item_t e = expected_q.pop_front();
                    if (out_data.char_word !== e.char_word)
                    begin
                        $error("char_word expected %h actual %h", e.char_word, out_data.char_word);
                        errors++;
                    end
                    if (out_data.flash_word !== e.flash_word)
                    begin
                        $error("flash_word expected %h actual %h", e.flash_word,
                               out_data.flash_word);
                        errors++;
                    end
                    if (out_data.flash_active !== e.flash_active)
                    begin
                        $error("flash_active expected %b actual %b", e.flash_active,
                               out_data.flash_active);
                        errors++;
                    end
                    if (out_data.changed !== e.changed)
                    begin
                        $error("changed expected %b actual %b", e.changed, out_data.changed);
                        errors++;
                    end
                    if (out_data.is_enabled !== e.is_enabled)
                    begin
                        $error("is_enabled expected %b actual %b", e.is_enabled,
                               out_data.is_enabled);
                        errors++;
                    end
                end
            end
        end
    end

    int stall_left;
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (out_valid && out_ready)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b1;
                stall_left <= 0;
            end
            else
            begin
                out_ready <= 1'b0;
                stall_left <= $urandom_range(0, 19);
            end
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("watchdog expired");
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        in_item_t it;
        out_item_t r;
        logic [7:0] b;
        errors = 0;
        accepted_in = 0;
        accepted_out = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        for (int i = 0; i < 16; i++) flashed[i] = '0;
        display_clear();
        mark_pos = 0;
        cust_left = 0;
        cust_word = 0;
        pt_pending = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset: reads show blanks and an empty flash store, disabled.
        it = '0;
        it.mode = MODE_READ;
        it.read_index = 4'd0;
        r = '0;
        r.char_word = BLANK_CH;
        table_rows.push_back(row_of(it, 1, r));
        it.read_index = 4'd15;
        table_rows.push_back(row_of(it, 1, r));
        // Unused mode 3 reads zero.
        it.mode = 2'd3;
        table_rows.push_back(row_of(it, 1, '0));
        // Reset pin low keeps the block disabled.
        it = pin_item(1'b0, 1'b1, 1'b1);
        it.read_index = 4'd0;
        table_rows.push_back(row_of(it, 1, '0));
        // Tick while idle.
        it = '0;
        it.mode = MODE_TICK;
        table_rows.push_back(row_of(it, 1, '0));
        // Reset pin rising enables the block.
        it = pin_item(1'b1, 1'b0, 1'b0);
        it.read_index = 4'd0;
        r = '0;
        r.changed = 1;
        r.is_enabled = 1;
        table_rows.push_back(row_of(it, 1, r));
        foreach (table_rows[k])
        begin
            r = display_predict(table_rows[k].item);
            if (table_rows[k].typed && r !== table_rows[k].result)
            begin
                $error("directed row %0d: predictor disagrees", k);
                errors++;
            end
            expected_q.push_back(table_rows[k].typed ? table_rows[k].result : r);
        end
        // The predictor has already been stepped, so drive without predicting again.
        foreach (table_rows[k])
            drive_item(table_rows[k].item);

        // Directed byte traffic: commands, marks, custom character, entry modes 0 and 3.
        send_byte(8'h41);
        send_byte(8'h2e);
        send_byte(8'h2c);
        send_byte(8'd58);
        send_byte(8'hff);
        send_byte(8'h80);
        send_byte(8'd37);
        send_read(4'd0);
        send_byte(8'ha3);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'hb3);

        // Hold off until the block has drained.
        idle_input();
        wait (expected_q.size() == 0);

        // Random part: mostly well-formed bytes, some raw pin noise, ticks and reads.
        while (accepted_in < 1950)
        begin
            case ($urandom_range(0, 19))
                0: send_item(pin_item(1'($urandom), 1'($urandom), 1'($urandom)));
                1, 2: send_item(pin_item(1'b1, 1'($urandom), 1'($urandom)));
                3, 4, 5: send_tick();
                6, 7, 8: send_read(4'($urandom));
                9: repeat (25) send_tick();
                default:
                begin
                    b = pick_byte();
                    if ($urandom_range(0, 5) == 0) b = 8'h80 | 8'($urandom_range(0, 127));
                    send_byte(b);
                end
            endcase
        end

        idle_input();
        wait (expected_q.size() == 0);
        repeat (50) @(posedge clk);
        $display("Covered %0d items in, %0d results out, with pin, tick, read and noise items.",
                 accepted_in, accepted_out);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ===== serial_alphanumeric_display_controller.f =====
+incdir+src
src/sadc_pkg.sv
src/serial_alphanumeric_display_controller.sv
test/tb_serial_alphanumeric_display_controller.sv
